>>> rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

   localparam int MAX_BLOCKS_DEF = 16;
   localparam int SIZE_BITS_DEF  = 16;

   localparam int SIZE_PORT_W  = 16;
   localparam int IDX_PORT_W   = 4;
   localparam int SCAN_PORT_W  = 5;
   localparam int TOTAL_W      = 32;
   localparam int STATUS_W     = 2;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_ALLOC = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOC  = 2'd0,
      ST_MISS   = 2'd1,
      ST_LOADED = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } tok_type;

endpackage

>>> rtl/first_fit_block_allocator.sv
// First-fit block allocator: cell chain holding block sizes, load/scan control, result register.
//
//  channel  ports                                  transfer
//  request  start, busy, req_command, req_size_value  start && !busy at clock edge
//  result   rsp_valid, rsp_status, rsp_block_index,   rsp_valid, one cycle, no backpressure
//           rsp_remaining_size, rsp_scan_compares, rsp_total_compares
//
//  A load keeps busy low, and the result strobes in the next cycle.
//  A request sends a token down the chain of MAX_BLOCKS cells, one cell per cycle;
//  busy stays high until the token reaches the end of the chain, and the result
//  strobes as busy falls. Reset clears the block count, the compare total and the
//  chain tokens; the block sizes need no clearing.
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
   parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_command,
   input  logic [ffba_pkg::SIZE_PORT_W-1:0] req_size_value,
   output logic                             rsp_valid,
   output logic [ffba_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ffba_pkg::IDX_PORT_W-1:0]  rsp_block_index,
   output logic [ffba_pkg::SIZE_PORT_W-1:0] rsp_remaining_size,
   output logic [ffba_pkg::SCAN_PORT_W-1:0] rsp_scan_compares,
   output logic [ffba_pkg::TOTAL_W-1:0]     rsp_total_compares
);
   import ffba_pkg::*;

   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int SZ_X_W = (SIZE_BITS > SIZE_PORT_W) ? SIZE_BITS : SIZE_PORT_W;
   localparam int IX_X_W = (IDX_W > IDX_PORT_W) ? IDX_W : IDX_PORT_W;
   localparam int SC_X_W = (CNT_W > SCAN_PORT_W) ? CNT_W : SCAN_PORT_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [SIZE_BITS-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;

   logic                 accept;
   logic                 full;
   logic                 load_en;
   logic [SZ_X_W-1:0]    req_ext;
   logic [SIZE_BITS-1:0] req_sz;
   logic [TOTAL_W:0]     sum;
   logic [CNT_W-1:0]     scan_sel;

   tok_type              ctl   [MAX_BLOCKS+1];
   logic [SIZE_BITS-1:0] req_c [MAX_BLOCKS+1];
   logic [IDX_W-1:0]     idx_c [MAX_BLOCKS+1];
   logic [SIZE_BITS-1:0] rem_c [MAX_BLOCKS+1];

   logic [SZ_X_W-1:0]    rem_ext;
   logic [IX_X_W-1:0]    idx_ext;
   logic [SC_X_W-1:0]    scan_ext;

   assign accept  = start && !busy;
   assign full    = count_ff >= CNT_W'(MAX_BLOCKS);
   assign req_ext = SZ_X_W'(req_size_value);
   assign req_sz  = req_ext[SIZE_BITS-1:0];
   assign load_en = accept && (req_command == CMD_LOAD) && !full;

   assign ctl[0].valid = accept && (req_command == CMD_ALLOC);
   assign ctl[0].hit   = 1'b0;
   assign req_c[0]     = req_sz;
   assign idx_c[0]     = '0;
   assign rem_c[0]     = '0;

   for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      ffba_cell #(
         .IDX       (g),
         .IDX_W     (IDX_W),
         .CNT_W     (CNT_W),
         .SIZE_BITS (SIZE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .count     (count_ff),
         .load_en   (load_en),
         .load_size (req_sz),
         .tok_in    (ctl[g]),
         .req_in    (req_c[g]),
         .idx_in    (idx_c[g]),
         .rem_in    (rem_c[g]),
         .tok_out   (ctl[g+1]),
         .req_out   (req_c[g+1]),
         .idx_out   (idx_c[g+1]),
         .rem_out   (rem_c[g+1])
      );
   end

   assign scan_sel = ctl[MAX_BLOCKS].hit ? CNT_W'(idx_c[MAX_BLOCKS]) : count_ff;
   assign sum      = {1'b0, total_ff} + (TOTAL_W + 1)'(scan_sel);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      scan_in      = scan_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_command == CMD_LOAD) begin
                  rsp_valid_in = 1'b1;
                  rem_in       = '0;
                  scan_in      = '0;
                  if (full) begin
                     status_in = ST_FULL;
                     idx_in    = '0;
                  end else begin
                     status_in = ST_LOADED;
                     idx_in    = count_ff[IDX_W-1:0];
                     count_in  = count_ff + CNT_W'(1);
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (ctl[MAX_BLOCKS].valid) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               scan_in      = scan_sel;
               total_in     = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
               if (ctl[MAX_BLOCKS].hit) begin
                  status_in = ST_ALLOC;
                  idx_in    = idx_c[MAX_BLOCKS];
                  rem_in    = rem_c[MAX_BLOCKS];
               end else begin
                  status_in = ST_MISS;
                  idx_in    = '0;
                  rem_in    = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      idx_ff    <= idx_in;
      rem_ff    <= rem_in;
      scan_ff   <= scan_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rem_ext  = SZ_X_W'(rem_ff);
   assign idx_ext  = IX_X_W'(idx_ff);
   assign scan_ext = SC_X_W'(scan_ff);

   assign busy               = (state_ff == S_SCAN);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_block_index    = idx_ext[IDX_PORT_W-1:0];
   assign rsp_remaining_size = rem_ext[SIZE_PORT_W-1:0];
   assign rsp_scan_compares  = scan_ext[SCAN_PORT_W-1:0];
   assign rsp_total_compares = total_ff;

endmodule

>>> rtl/ffba_cell.sv
// One table cell: holds a block size and tests/updates it as the scan token passes.
module ffba_cell #(
   parameter int IDX       = 0,
   parameter int IDX_W     = 4,
   parameter int CNT_W     = 5,
   parameter int SIZE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CNT_W-1:0]     count,
   input  logic                 load_en,
   input  logic [SIZE_BITS-1:0] load_size,
   input  ffba_pkg::tok_type    tok_in,
   input  logic [SIZE_BITS-1:0] req_in,
   input  logic [IDX_W-1:0]     idx_in,
   input  logic [SIZE_BITS-1:0] rem_in,
   output ffba_pkg::tok_type    tok_out,
   output logic [SIZE_BITS-1:0] req_out,
   output logic [IDX_W-1:0]     idx_out,
   output logic [SIZE_BITS-1:0] rem_out
);
   import ffba_pkg::*;

   logic [SIZE_BITS-1:0] size_ff, size_in;
   tok_type              tok_ff, tok_in_nx;
   logic [SIZE_BITS-1:0] req_ff;
   logic [IDX_W-1:0]     idx_ff, idx_nx;
   logic [SIZE_BITS-1:0] rem_ff, rem_nx;
   logic                 loaded;
   logic                 fits;
   logic [SIZE_BITS-1:0] diff;

   assign loaded = CNT_W'(IDX) < count;
   assign fits   = tok_in.valid && !tok_in.hit && loaded && (req_in <= size_ff);
   assign diff   = size_ff - req_in;

   always_comb begin
      size_in = size_ff;
      if (load_en && (count == CNT_W'(IDX))) begin
         size_in = load_size;
      end else if (fits) begin
         size_in = diff;
      end
      tok_in_nx.valid = tok_in.valid;
      tok_in_nx.hit   = tok_in.hit | fits;
      idx_nx          = fits ? IDX_W'(IDX) : idx_in;
      rem_nx          = fits ? diff : rem_in;
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      req_ff  <= req_in;
      idx_ff  <= idx_nx;
      rem_ff  <= rem_nx;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_nx;
      end
   end

   assign tok_out = tok_ff;
   assign req_out = req_ff;
   assign idx_out = idx_ff;
   assign rem_out = rem_ff;

endmodule

>>> rtl/ffba_checker.sv
// Port-level checks for the first-fit block allocator, bound to the top level.
module ffba_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             req_command,
   input logic                             rsp_valid,
   input logic [ffba_pkg::STATUS_W-1:0]    rsp_status,
   input logic [ffba_pkg::IDX_PORT_W-1:0]  rsp_block_index,
   input logic [ffba_pkg::SIZE_PORT_W-1:0] rsp_remaining_size,
   input logic [ffba_pkg::SCAN_PORT_W-1:0] rsp_scan_compares
);
   import ffba_pkg::*;

   a_busy_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && (req_command == CMD_ALLOC)))
      else $error("busy rose without an accepted request");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start && !busy && (req_command == CMD_LOAD)) || $fell(busy)))
      else $error("result strobe without a finished transfer");

   a_load_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(start && !busy && (req_command == CMD_LOAD)) |->
      (rsp_status == ST_LOADED) || (rsp_status == ST_FULL))
      else $error("load produced an allocation status");

   a_alloc_scans: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ALLOC) |->
      rsp_scan_compares[IDX_PORT_W-1:0] == rsp_block_index)
      else $error("scan count disagrees with allocated index");

   a_rem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_ALLOC) |-> rsp_remaining_size == '0)
      else $error("remaining size set on a non-allocation result");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_command        (req_command),
   .rsp_valid          (rsp_valid),
   .rsp_status         (rsp_status),
   .rsp_block_index    (rsp_block_index),
   .rsp_remaining_size (rsp_remaining_size),
   .rsp_scan_compares  (rsp_scan_compares)
);
